>>> sv/ced_pkg.sv
// Curb edge detector shared package: types, register codes, CORDIC constants.
// Used by the CORDIC, datapath, controller, top level and testbench; depends on nothing.
`default_nettype none
package ced_pkg;

  localparam int MAX_POINTS_DEF      = 1024;
  localparam int ANGLE_FRAC_BITS_DEF = 12;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int XY_W         = 36;
  localparam int Z_W          = 27;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 27'sd26353589;

  localparam logic [1:0] REG_HEIGHT_STEP     = 2'd0;
  localparam logic [1:0] REG_SLOPE_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_CHECK_WINDOW    = 2'd2;
  localparam logic [1:0] REG_WHEEL_EDGE      = 2'd3;

  typedef struct packed {
    logic wr_en;
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_ref;
    logic cordic_start;
    logic cordic_sel;     // 0: pair a-b, 1: pair b-c
    logic save_s1;
    logic set_left;
    logic set_right;
    logic clr_result;
    logic ld_tag;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic lt_neg;
    logic lt_pos;
    logic cordic_done;
    logic brk;
    logic step_high;
    logic win_out;
    logic near_drive;
    logic out_busy;
  } st_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 27'sd13176795;
      5'd1:  r = 27'sd7778716;
      5'd2:  r = 27'sd4110060;
      5'd3:  r = 27'sd2086331;
      5'd4:  r = 27'sd1047214;
      5'd5:  r = 27'sd524117;
      5'd6:  r = 27'sd262123;
      5'd7:  r = 27'sd131069;
      5'd8:  r = 27'sd65536;
      5'd9:  r = 27'sd32768;
      5'd10: r = 27'sd16384;
      5'd11: r = 27'sd8192;
      5'd12: r = 27'sd4096;
      5'd13: r = 27'sd2048;
      5'd14: r = 27'sd1024;
      5'd15: r = 27'sd512;
      5'd16: r = 27'sd256;
      5'd17: r = 27'sd128;
      5'd18: r = 27'sd64;
      5'd19: r = 27'sd32;
      5'd20: r = 27'sd16;
      5'd21: r = 27'sd8;
      5'd22: r = 27'sd4;
      5'd23: r = 27'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] abs_diff16(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
    logic signed [16:0] d;
    d = {a[15], a} - {b[15], b};
    return d[16] ? 16'(-d) : d[15:0];
  endfunction

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

endpackage
`default_nettype wire

>>> sv/ced_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ced_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/ced_cordic.sv
// Iterative vectoring CORDIC: atan2(y0, x0) for non-negative operands.
// One rotation per cycle, 24 rotations for nonzero operands; depends on ced_pkg.
`default_nettype none
module ced_cordic #(
  parameter int ANGLE_FRAC_BITS = ced_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int ANG_W = ANGLE_FRAC_BITS + 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [15:0]             y0,
  input  wire logic [15:0]             x0,
  output logic                         done,
  output logic signed [ANG_W-1:0]      angle
);

  localparam int XY_W = ced_pkg::XY_W;
  localparam int Z_W  = ced_pkg::Z_W;
  localparam int RND  = 1 << (23 - ANGLE_FRAC_BITS);
  localparam int SH   = 24 - ANGLE_FRAC_BITS;
  localparam logic [ced_pkg::STEP_W-1:0] LAST_STEP =
    ced_pkg::STEP_W'(ced_pkg::CORDIC_STEPS - 1);

  logic                          busy;
  logic [ced_pkg::STEP_W-1:0]    step;
  logic signed [XY_W-1:0]        x, y, dx, dy;
  logic signed [Z_W-1:0]         z, zr, zs;

  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (y0 == 16'd0 || x0 == 16'd0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= $signed({{(XY_W-32){1'b0}}, x0, 16'h0000});
      y <= $signed({{(XY_W-32){1'b0}}, y0, 16'h0000});
      if (y0 != 16'd0 && x0 == 16'd0) begin
        z <= ced_pkg::HALF_PI_Q24;
      end else begin
        z <= '0;
      end
    end else if (busy) begin
      if (!y[XY_W-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ced_pkg::atan_q24(step);
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ced_pkg::atan_q24(step);
      end
    end
  end

  // round half up to the output angle resolution
  assign zr    = z + Z_W'(RND);
  assign zs    = zr >>> SH;
  assign angle = zs[ANG_W-1:0];

endmodule
`default_nettype wire

>>> sv/ced_datapath.sv
// Curb edge detector datapath: point memories, point registers, CORDIC,
// tests, configuration registers and output register. Depends on ced_pkg,
// ced_ram and ced_cordic.
`default_nettype none
module ced_datapath #(
  parameter int MAX_POINTS      = ced_pkg::MAX_POINTS_DEF,
  parameter int ANGLE_FRAC_BITS = ced_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ced_pkg::cmd_t   cmd,
  input  wire logic [AW-1:0]   addr,
  input  wire logic [63:0]     s_tdata,
  input  wire logic            cfg_valid,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [14:0]     cfg_data,
  input  wire logic            m_tready,
  output logic                 m_tvalid,
  output logic [63:0]          m_tdata,
  output ced_pkg::st_t         st
);

  localparam int ANG_W = ANGLE_FRAC_BITS + 3;
  localparam int CMP_W = (ANG_W + 2 > 16) ? ANG_W + 2 : 16;

  logic [14:0] height_step, check_window, wheel_edge;
  logic [13:0] slope_threshold;

  logic signed [15:0] rd_lat, rd_h;
  logic signed [15:0] lat_a, h_a, lat_b, h_b, lat_c, h_c;
  logic [16:0]        ref_abs;
  logic signed [ANG_W-1:0] s1, ang;
  logic [14:0] left, right, out_left, out_right;
  logic [31:0] held_tag, out_tag;
  logic        cdone;
  logic [15:0] cy, cx;

  ced_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_lat_ram (
    .clk(clk), .we(cmd.wr_en), .waddr(addr), .wdata(s_tdata[15:0]),
    .raddr(addr), .rdata(rd_lat)
  );

  ced_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_h_ram (
    .clk(clk), .we(cmd.wr_en), .waddr(addr), .wdata(s_tdata[31:16]),
    .raddr(addr), .rdata(rd_h)
  );

  assign cy = cmd.cordic_sel ? ced_pkg::abs_diff16(lat_b, lat_c)
                             : ced_pkg::abs_diff16(lat_a, lat_b);
  assign cx = cmd.cordic_sel ? ced_pkg::abs_diff16(h_b, h_c)
                             : ced_pkg::abs_diff16(h_a, h_b);

  ced_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cmd.cordic_start), .y0(cy), .x0(cx),
    .done(cdone), .angle(ang)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      height_step     <= 15'd50;
      slope_threshold <= 14'd2144;
      check_window    <= 15'd300;
      wheel_edge      <= 15'd200;
    end else if (cfg_valid) begin
      case (cfg_index)
        ced_pkg::REG_HEIGHT_STEP:     height_step     <= cfg_data;
        ced_pkg::REG_SLOPE_THRESHOLD: slope_threshold <= cfg_data[13:0];
        ced_pkg::REG_CHECK_WINDOW:    check_window    <= cfg_data;
        ced_pkg::REG_WHEEL_EDGE:      wheel_edge      <= cfg_data;
        default: ;
      endcase
    end
  end

  // |lateral| of a curb point, -32768 saturates
  function automatic logic [14:0] sat15(input logic signed [15:0] v);
    logic [16:0] a;
    a = ced_pkg::abs17(v);
    return a[15] ? 15'h7fff : a[14:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      lat_a <= rd_lat;
      h_a   <= rd_h;
    end
    if (cmd.ld_b) begin
      lat_b <= rd_lat;
      h_b   <= rd_h;
    end
    if (cmd.ld_c) begin
      lat_c <= rd_lat;
      h_c   <= rd_h;
    end
    if (cmd.ld_ref) begin
      ref_abs <= ced_pkg::abs17(lat_c);
    end
    if (cmd.save_s1) begin
      s1 <= ang;
    end
    if (cmd.ld_tag) begin
      held_tag <= s_tdata[63:32];
    end
    if (cmd.clr_result) begin
      left  <= '0;
      right <= '0;
    end
    if (cmd.set_left) begin
      left <= sat15(lat_b);
    end
    if (cmd.set_right) begin
      right <= sat15(lat_b);
    end
    if (cmd.emit) begin
      out_left  <= left;
      out_right <= right;
      out_tag   <= held_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, out_tag, out_right, out_left};

  // status tests
  logic signed [16:0]      edge_s, rd_lat_x;
  logic signed [17:0]      step_d;
  logic [15:0]             hd;
  logic signed [17:0]      wd;
  logic [16:0]             wd_abs;
  logic signed [CMP_W-1:0] s1x, angx, dd;
  logic [CMP_W-1:0]        dmag;

  assign edge_s   = $signed({2'b00, wheel_edge});
  assign rd_lat_x = {rd_lat[15], rd_lat};
  assign step_d   = ({{2{h_a[15]}}, h_a} - {{2{h_c[15]}}, h_c}) <<< 1;
  assign hd       = ced_pkg::abs_diff16(rd_h, h_a);
  assign wd       = $signed({1'b0, ced_pkg::abs17(rd_lat)}) - $signed({1'b0, ref_abs});
  assign wd_abs   = wd[17] ? 17'(-wd) : wd[16:0];
  assign s1x      = CMP_W'(s1);
  assign angx     = CMP_W'(ang);
  assign dd       = s1x - angx;
  assign dmag     = dd[CMP_W-1] ? CMP_W'(-dd) : CMP_W'(dd);

  always_comb begin
    st             = '0;
    st.lt_neg      = rd_lat_x < -edge_s;
    st.lt_pos      = rd_lat_x < edge_s;
    st.cordic_done = cdone;
    st.brk         = dmag > CMP_W'(slope_threshold);
    st.step_high   = step_d > $signed({3'b000, height_step});
    st.win_out     = wd_abs >= {2'b00, check_window};
    st.near_drive  = {hd, 1'b0} < {2'b00, height_step};
    st.out_busy    = m_tvalid && !m_tready;
  end

endmodule
`default_nettype wire

>>> sv/ced_ctrl.sv
// Curb edge detector controller: point loading, outward scans, candidate
// sequencing and pothole walk. Depends on ced_pkg.
`default_nettype none
module ced_ctrl #(
  parameter int MAX_POINTS = ced_pkg::MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_tlast,
  output logic               s_tready,
  input  wire ced_pkg::st_t  st,
  output ced_pkg::cmd_t      cmd,
  output logic [AW-1:0]      addr
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LSCAN    = 5'd1;
  localparam logic [4:0] S_LSCAN_CK = 5'd2;
  localparam logic [4:0] S_LLOOP    = 5'd3;
  localparam logic [4:0] S_RSCAN    = 5'd4;
  localparam logic [4:0] S_RSCAN_CK = 5'd5;
  localparam logic [4:0] S_RLOOP    = 5'd6;
  localparam logic [4:0] S_FA       = 5'd7;
  localparam logic [4:0] S_FB       = 5'd8;
  localparam logic [4:0] S_FC       = 5'd9;
  localparam logic [4:0] S_FD       = 5'd10;
  localparam logic [4:0] S_C1       = 5'd11;
  localparam logic [4:0] S_W1       = 5'd12;
  localparam logic [4:0] S_C2       = 5'd13;
  localparam logic [4:0] S_W2       = 5'd14;
  localparam logic [4:0] S_CHK      = 5'd15;
  localparam logic [4:0] S_WRD      = 5'd16;
  localparam logic [4:0] S_WCK      = 5'd17;
  localparam logic [4:0] S_EMIT     = 5'd18;

  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

  logic [4:0]    state, state_next;
  logic [CW-1:0] count, count_next, n, n_next, i, i_next, j, j_next, k, k_next;
  logic          side, side_next;   // 0 left, 1 right
  logic [CW-1:0] pb, pc;
  logic          full, accept;

  assign full   = count == MAXC;
  assign accept = s_tvalid && s_tready;
  assign pb     = side ? j + 1'b1 : j - 1'b1;
  assign pc     = side ? j + CW'(2) : j - CW'(2);

  always_comb begin
    state_next = state;
    count_next = count;
    n_next     = n;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    side_next  = side;
    cmd        = '0;
    addr       = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        addr     = count[AW-1:0];
        if (accept) begin
          if (!full) begin
            cmd.wr_en  = 1'b1;
            count_next = count + 1'b1;
          end
          if (s_tlast) begin
            cmd.ld_tag     = 1'b1;
            cmd.clr_result = 1'b1;
            n_next         = full ? count : count + 1'b1;
            count_next     = '0;
            i_next         = CW'(1);
            state_next     = S_LSCAN;
          end
        end
      end
      S_LSCAN: begin
        addr = i[AW-1:0];
        if (i < n) begin
          state_next = S_LSCAN_CK;
        end else begin
          j_next     = i - 1'b1;
          state_next = S_LLOOP;
        end
      end
      S_LSCAN_CK: begin
        if (st.lt_neg) begin
          i_next     = i + 1'b1;
          state_next = S_LSCAN;
        end else begin
          j_next     = i - 1'b1;
          state_next = S_LLOOP;
        end
      end
      S_LLOOP: begin
        if (j > CW'(2)) begin
          side_next  = 1'b0;
          state_next = S_FA;
        end else begin
          state_next = S_RSCAN;
        end
      end
      S_RSCAN: begin
        addr = i[AW-1:0];
        if (i < n) begin
          state_next = S_RSCAN_CK;
        end else begin
          j_next     = i;
          state_next = S_RLOOP;
        end
      end
      S_RSCAN_CK: begin
        if (st.lt_pos) begin
          i_next     = i + 1'b1;
          state_next = S_RSCAN;
        end else begin
          j_next     = i;
          state_next = S_RLOOP;
        end
      end
      S_RLOOP: begin
        if ({1'b0, j} + (CW+1)'(3) < {1'b0, n}) begin
          side_next  = 1'b1;
          state_next = S_FA;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FA: begin
        addr       = j[AW-1:0];
        state_next = S_FB;
      end
      S_FB: begin
        addr       = pb[AW-1:0];
        cmd.ld_a   = 1'b1;
        state_next = S_FC;
      end
      S_FC: begin
        addr       = pc[AW-1:0];
        cmd.ld_b   = 1'b1;
        state_next = S_FD;
      end
      S_FD: begin
        cmd.ld_c   = 1'b1;
        state_next = S_C1;
      end
      S_C1: begin
        cmd.cordic_start = 1'b1;
        state_next       = S_W1;
      end
      S_W1: begin
        if (st.cordic_done) begin
          cmd.save_s1 = 1'b1;
          state_next  = S_C2;
        end
      end
      S_C2: begin
        cmd.cordic_start = 1'b1;
        cmd.cordic_sel   = 1'b1;
        state_next       = S_W2;
      end
      S_W2: begin
        cmd.cordic_sel = 1'b1;
        if (st.cordic_done) begin
          if (st.brk) begin
            state_next = S_CHK;
          end else if (side) begin
            j_next     = j + 1'b1;
            state_next = S_RLOOP;
          end else begin
            j_next     = j - 1'b1;
            state_next = S_LLOOP;
          end
        end
      end
      S_CHK: begin
        if (st.step_high) begin
          cmd.set_left  = !side;
          cmd.set_right = side;
          state_next    = side ? S_EMIT : S_RSCAN;
        end else begin
          cmd.ld_ref = 1'b1;
          k_next     = pc;
          state_next = S_WRD;
        end
      end
      S_WRD: begin
        addr       = k[AW-1:0];
        state_next = S_WCK;
      end
      S_WCK: begin
        if (st.win_out || (!st.near_drive &&
                           (side ? (k + 1'b1 == n) : (k == '0)))) begin
          // out of window or walked off the buffer: curb stands
          cmd.set_left  = !side;
          cmd.set_right = side;
          state_next    = side ? S_EMIT : S_RSCAN;
        end else if (st.near_drive) begin
          // pothole, try next candidate
          if (side) begin
            j_next     = j + 1'b1;
            state_next = S_RLOOP;
          end else begin
            j_next     = j - 1'b1;
            state_next = S_LLOOP;
          end
        end else begin
          k_next     = side ? k + 1'b1 : k - 1'b1;
          state_next = S_WRD;
        end
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      n     <= n_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      side  <= side_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/curb_edge_detector_core.sv
// Curb edge detector top level: controller plus datapath.
// Depends on ced_pkg, ced_ctrl and ced_datapath.
//
// Points of one lidar cross-section stream in sorted by lateral position, one
// transaction per cycle, up to MAX_POINTS kept (extra points are dropped, a
// dropped last point still closes the scan). After the last point the block
// stops taking input and searches outward from the inner wheel edges on both
// sides, then posts one result (left and right curb distance, 0 when none,
// and the scan tag). Locating the wheel edges reads and tests every point
// passed; each candidate step takes three memory reads and two 24-step
// CORDIC atan2 evaluations on the shared rotator; a pothole recheck reads
// each point it visits. Memory reads go through the registered read port
// of the point RAMs, one point per read. A finished result waits in the
// output register while the next scan loads.
`default_nettype none
module curb_edge_detector_core #(
  parameter int MAX_POINTS      = ced_pkg::MAX_POINTS_DEF,
  parameter int ANGLE_FRAC_BITS = ced_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // lateral_mm[15:0], height_mm[31:16], scan_tag[63:32]
  input  wire logic        s_tlast,   // last_point
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // left_curb_mm[14:0], right_curb_mm[29:15],
                                      // result_tag[61:30], zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);

  ced_pkg::cmd_t  cmd;
  ced_pkg::st_t   st;
  logic [AW-1:0]  addr;

  assign cfg_ready = 1'b1;

  ced_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tlast(s_tlast),
    .s_tready(s_tready), .st(st), .cmd(cmd), .addr(addr)
  );

  ced_datapath #(.MAX_POINTS(MAX_POINTS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .addr(addr), .s_tdata(s_tdata),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .st(st)
  );

endmodule
`default_nettype wire

>>> sv/ced_checker.sv
// Port-level checks for curb_edge_detector_core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module ced_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after last point");

  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result posted while loading");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:62] == 2'b00)
    else $error("result padding not zero");

endmodule

bind curb_edge_detector_core ced_checker u_ced_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

>>> tb/curb_edge_detector_core_tb.sv
// Self-checking testbench for curb_edge_detector_core: streams lidar scans,
// predicts each curb result in-bench and checks every output transaction.
// Depends on ced_pkg and the core RTL.
`timescale 1ns / 1ps
module curb_edge_detector_core_tb;

  localparam int NPTS     = 64;
  localparam int AFRAC    = 12;
  localparam int WD_LIMIT = 400000;
  localparam int SETTLE   = 64;

  typedef struct {
    logic [14:0] left;
    logic [14:0] right;
    logic [31:0] tag;
  } curb_t;

  typedef struct {
    logic signed [15:0] lat;
    logic signed [15:0] hgt;
    bit                 last;
    logic [31:0]        tag;
    bit                 typed;
    logic [14:0]        el;
    logic [14:0]        er;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = ced_pkg::REG_HEIGHT_STEP;
  logic [14:0] cfg_data = '0;

  always #2 clk = ~clk;

  curb_edge_detector_core #(.MAX_POINTS(NPTS), .ANGLE_FRAC_BITS(AFRAC)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  int          pt_lat [NPTS];
  int          pt_hgt [NPTS];
  int          pt_cnt;
  int          step_mm, slope_thr, win_mm, edge_mm;
  curb_t       curb_q[$];
  int          errors;
  int          src_idle_pct, rx_idle_pct;
  int          sent;
  int          idle_cycles;
  row_t        rows[$];

  function automatic longint atan_q24_of(int i);
    longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                      131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  // atan2(y, x) for y, x >= 0, rounded to 2^-12 rad
  function automatic longint slope_angle(int y0, int x0);
    longint x, y, z, dx, dy;
    x = longint'(x0) * 65536;
    y = longint'(y0) * 65536;
    z = 0;
    if (y0 == 0) return 0;
    if (x0 == 0) begin
      z = 26353589;
    end else begin
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_q24_of(i);
        end else begin
          x -= dx; y += dy; z -= atan_q24_of(i);
        end
      end
    end
    return (z + (longint'(1) << (23 - AFRAC))) >>> (24 - AFRAC);
  endfunction

  function automatic bit slope_break(int a, int b, int c);
    longint s1, s2, d;
    s1 = slope_angle(iabs(pt_lat[a] - pt_lat[b]), iabs(pt_hgt[a] - pt_hgt[b]));
    s2 = slope_angle(iabs(pt_lat[b] - pt_lat[c]), iabs(pt_hgt[b] - pt_hgt[c]));
    d = s1 - s2;
    if (d < 0) d = -d;
    return d > slope_thr;
  endfunction

  // 0 when the candidate step is a pothole
  function automatic bit still_curb(int drive, int k, int dir, int n);
    int ref_mm;
    ref_mm = iabs(pt_lat[k]);
    if (2 * (drive - pt_hgt[k]) > step_mm) return 1;
    while (k >= 0 && k < n) begin
      if (iabs(iabs(pt_lat[k]) - ref_mm) >= win_mm) break;
      if (2 * iabs(pt_hgt[k] - drive) < step_mm) return 0;
      k += dir;
    end
    return 1;
  endfunction

  function automatic logic [14:0] sat15(int v);
    v = iabs(v);
    return v > 32767 ? 15'h7fff : 15'(v);
  endfunction

  function automatic bit find_curbs(logic signed [15:0] lat, logic signed [15:0] hgt,
                                    bit last, logic [31:0] tag, output curb_t res);
    int n, i, j;
    res = '{0, 0, tag};
    if (pt_cnt < NPTS) begin
      pt_lat[pt_cnt] = lat;
      pt_hgt[pt_cnt] = hgt;
      pt_cnt++;
    end
    if (!last) return 0;
    n = pt_cnt;
    i = 1;
    while (i < n && pt_lat[i] < -edge_mm) i++;
    for (j = i - 1; j > 2; j--)
      if (slope_break(j, j - 1, j - 2) && still_curb(pt_hgt[j], j - 2, -1, n)) begin
        res.left = sat15(pt_lat[j - 1]);
        break;
      end
    while (i < n && pt_lat[i] < edge_mm) i++;
    for (j = i; j + 3 < n; j++)
      if (slope_break(j, j + 1, j + 2) && still_curb(pt_hgt[j], j + 2, 1, n)) begin
        res.right = sat15(pt_lat[j + 1]);
        break;
      end
    pt_cnt = 0;
    return 1;
  endfunction

  // one point transaction; typed expectation overrides the prediction
  task automatic send_point(row_t r);
    curb_t res;
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.tag, r.hgt, r.lat};
    s_tlast  <= r.last;
    do @(posedge clk); while (!s_tready);
    sent++;
    if (find_curbs(r.lat, r.hgt, r.last, r.tag, res)) begin
      if (r.typed) res = '{r.el, r.er, r.tag};
      curb_q = {curb_q, res};
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (curb_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 15'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ced_pkg::REG_HEIGHT_STEP:     step_mm   = val;
      ced_pkg::REG_SLOPE_THRESHOLD: slope_thr = val;
      ced_pkg::REG_CHECK_WINDOW:    win_mm    = val;
      default:                      edge_mm   = val;
    endcase
  endtask

  task automatic write_all(int hs, int st, int cw, int we);
    drain();
    write_reg(ced_pkg::REG_HEIGHT_STEP, hs);
    write_reg(ced_pkg::REG_SLOPE_THRESHOLD, st);
    write_reg(ced_pkg::REG_CHECK_WINDOW, cw);
    write_reg(ced_pkg::REG_WHEEL_EDGE, we);
  endtask

  task automatic add_row(int lat, int hgt, bit last, logic [31:0] tag,
                         bit typed = 0, int el = 0, int er = 0);
    row_t r;
    r = '{16'(lat), 16'(hgt), last, tag, typed, 15'(el), 15'(er)};
    rows = {rows, r};
  endtask

  // kind 0: road profile with curbs/potholes, 1: random noise, 2: flat
  task automatic send_scan(int n, int kind);
    row_t r;
    int lat, road, lcurb, rcurb, lh, rh, pot;
    lat   = -$urandom_range(300, 6000);
    road  = $urandom_range(0, 400) - 200;
    lcurb = -$urandom_range(0, 3000);
    rcurb = $urandom_range(0, 3000);
    lh    = $urandom_range(0, 300);
    rh    = $urandom_range(0, 300);
    pot   = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      r.last  = (k == n - 1);
      r.tag   = $urandom;
      r.typed = 0;
      if (kind == 1) begin
        r.lat = 16'($urandom);
        r.hgt = 16'($urandom);
      end else begin
        lat += (kind == 2) ? 30 : $urandom_range(20, 400);
        r.lat = 16'(lat);
        if (kind == 2) r.hgt = 16'(road);
        else if (lat < lcurb) r.hgt = 16'(road + lh + $urandom_range(0, 6));
        else if (lat > rcurb) r.hgt = 16'(road + rh + $urandom_range(0, 6));
        else if (pot == 0 && k % 5 == 2) r.hgt = 16'(road - $urandom_range(20, 200));
        else r.hgt = 16'(road + $urandom_range(0, 6));
      end
      send_point(r);
    end
  endtask

  // output side: random stall, check against the oldest expectation
  always @(posedge clk) begin
    curb_t e;
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (curb_q.size() == 0) begin
        $error("unexpected result transaction %h", m_tdata);
        errors++;
      end else begin
        e = curb_q.pop_front();
        if (m_tdata[14:0] !== e.left) begin
          $error("left_curb_mm exp %0d got %0d", e.left, m_tdata[14:0]);
          errors++;
        end
        if (m_tdata[29:15] !== e.right) begin
          $error("right_curb_mm exp %0d got %0d", e.right, m_tdata[29:15]);
          errors++;
        end
        if (m_tdata[61:30] !== e.tag) begin
          $error("result_tag exp %h got %h", e.tag, m_tdata[61:30]);
          errors++;
        end
      end
    end
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("curb_edge_detector_core regression: fail");
      $finish;
    end
  end

  initial begin
    int target;
    sent = 0; pt_cnt = 0;
    step_mm = 50; slope_thr = 2144; win_mm = 300; edge_mm = 200;
    src_idle_pct = 15; rx_idle_pct = 82;
    foreach (pt_lat[k]) begin
      pt_lat[k] = 0;
      pt_hgt[k] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short scans with obvious answers, then a two-sided curb
    add_row(0, 0, 1, 32'hffff_ffff, 1, 0, 0);
    add_row(-32768, -32768, 0, 32'h0);
    add_row(32767, 32767, 1, 32'h0, 1, 0, 0);
    add_row(-32768, 150, 0, 32'h1);
    add_row(-32767, 150, 0, 32'h1);
    add_row(-1500, 0, 0, 32'h1);
    add_row(-1200, 0, 0, 32'h1);
    add_row(-900, 0, 0, 32'h1);
    add_row(-600, 0, 0, 32'h1);
    add_row(0, 0, 0, 32'h1);
    add_row(600, 0, 0, 32'h1);
    add_row(900, 0, 0, 32'h1);
    add_row(1200, 0, 0, 32'h1);
    add_row(1500, 150, 0, 32'h1);
    add_row(1600, 150, 0, 32'h1);
    add_row(1900, 150, 0, 32'h1);
    add_row(2200, 150, 1, 32'h8000_0001);
    // pothole on the right: height returns within the window
    add_row(-400, 0, 0, 32'h2);
    add_row(-200, 0, 0, 32'h2);
    add_row(0, 0, 0, 32'h2);
    add_row(300, 0, 0, 32'h2);
    add_row(400, -120, 0, 32'h2);
    add_row(500, 0, 0, 32'h2);
    add_row(600, 0, 0, 32'h2);
    add_row(700, 0, 1, 32'h5a5a_a5a5);
    foreach (rows[k]) send_point(rows[k]);

    write_all($urandom_range(0, 32767), $urandom_range(0, 12868),
              $urandom_range(0, 32767), $urandom_range(0, 32767));
    write_all(0, 0, 0, 0);
    for (int s = 0; s < 4; s++) send_scan($urandom_range(1, 20), s % 3);
    write_all(32767, 12868, 32767, 32767);
    for (int s = 0; s < 4; s++) send_scan($urandom_range(1, 20), s % 3);
    write_all(50, 2144, 300, 200);

    // random part in three idling regimes
    for (int m = 0; m < 3; m++) begin
      src_idle_pct = (m == 0) ? 15 : (m == 1) ? 82 : 0;
      rx_idle_pct  = (m == 0) ? 82 : (m == 1) ? 15 : 0;
      target = sent + 100;
      while (sent < target) begin
        if ($urandom_range(5) == 0)
          write_all($urandom_range(0, 400), $urandom_range(0, 6000),
                    $urandom_range(0, 1500), $urandom_range(0, 1500));
        send_scan($urandom_range(1, 30), ($urandom_range(9) < 7) ? 0 : 1);
      end
    end
    // buffer overflow: the last point is dropped but still closes the scan
    send_scan(NPTS + 6, 2);
    send_scan(12, 0);

    drain();
    if (errors == 0 && curb_q.size() == 0)
      $display("curb_edge_detector_core regression: pass");
    else
      $display("curb_edge_detector_core regression: fail");
    $finish;
  end

endmodule

>>> curb_edge_detector_core.f
sv/ced_pkg.sv
sv/ced_ram.sv
sv/ced_cordic.sv
sv/ced_datapath.sv
sv/ced_ctrl.sv
sv/curb_edge_detector_core.sv
sv/ced_checker.sv
tb/curb_edge_detector_core_tb.sv
